// File: rtl/core/gblp_pkg.sv
`timescale 1ns / 1ps
package gblp_pkg;
   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 64;
   localparam int CELLS = GRID_COLS * GRID_ROWS;
   localparam int COL_W = $clog2(GRID_COLS);
   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int MAX_BRUSH = 12;
   localparam int REACH = 2;
   localparam int REACH_SPAN = 2 * REACH + 1;
   localparam int SPAN_W = $clog2(REACH_SPAN + 1);

   // signed coordinate width holding grid coordinates plus offsets
   localparam int CRD_W = 12;

   // request codes
   localparam logic [2:0] REQ_PRESS_PAINT = 3'd0;
   localparam logic [2:0] REQ_PRESS_ERASE = 3'd1;
   localparam logic [2:0] REQ_MOVE        = 3'd2;
   localparam logic [2:0] REQ_RELEASE     = 3'd3;
   localparam logic [2:0] REQ_LOAD_BODY   = 3'd4;
   localparam logic [2:0] REQ_LOAD_ENTR   = 3'd5;
   localparam logic [2:0] REQ_CLEAR       = 3'd6;
   localparam logic [2:0] REQ_READ        = 3'd7;

   // layer codes
   localparam logic [1:0] LAYER_NONE  = 2'd0;
   localparam logic [1:0] LAYER_BODY  = 2'd1;
   localparam logic [1:0] LAYER_ENTR  = 2'd2;
   localparam logic [1:0] LAYER_ERASE = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_WIDTH    = 3'd0;
   localparam logic [2:0] CSR_HEIGHT   = 3'd1;
   localparam logic [2:0] CSR_BRUSH    = 3'd2;
   localparam logic [2:0] CSR_LAYER    = 3'd3;
   localparam logic [2:0] CSR_EDITABLE = 3'd4;

   // datapath operations issued by the controller
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_CLR_STEP  = 4'd1;  // clear one cell, advance sweep
   localparam logic [3:0] OP_LATCH     = 4'd2;  // capture item
   localparam logic [3:0] OP_LINE_INIT = 4'd3;  // set up line walk
   localparam logic [3:0] OP_STAMP_INIT= 4'd4;  // set up brush at line point
   localparam logic [3:0] OP_RD_ISSUE  = 4'd5;  // issue read of brush cell
   localparam logic [3:0] OP_RD_WAIT   = 4'd6;  // read data arrives
   localparam logic [3:0] OP_WR_CELL   = 4'd7;  // apply stamp to brush cell
   localparam logic [3:0] OP_NB_ISSUE  = 4'd8;  // issue neighbor read
   localparam logic [3:0] OP_NB_CHECK  = 4'd9;  // test neighbor
   localparam logic [3:0] OP_LINE_STEP = 4'd10; // Bresenham step
   localparam logic [3:0] OP_FINISH    = 4'd11; // build result

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic clr_last;      // sweep at last cell
      logic cell_in;       // current brush cell inside grid
      logic brush_last;    // last brush cell
      logic need_nb;       // cell needs reach check
      logic nb_hit;        // neighbor found (registered data valid and set)
      logic nb_last;       // last neighbor
      logic line_last;     // line point equals end
      logic is_clear;      // latched item is clear all
      logic is_stroke;     // latched item stamps
      logic is_move;       // latched item is a move
   } sts_type;
endpackage

// File: rtl/core/gblp_ctrl.sv
`timescale 1ns / 1ps
module gblp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gblp_pkg::sts_type sts,
   output gblp_pkg::cmd_type cmd
);
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_LINE   = 4'd3;
   localparam logic [3:0] S_STAMP  = 4'd4;
   localparam logic [3:0] S_RD     = 4'd5;
   localparam logic [3:0] S_RDW    = 4'd6;
   localparam logic [3:0] S_NB     = 4'd7;
   localparam logic [3:0] S_NBW    = 4'd8;
   localparam logic [3:0] S_WR     = 4'd9;
   localparam logic [3:0] S_STEP   = 4'd10;
   localparam logic [3:0] S_FIN    = 4'd11;

   logic [3:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   // sequence one item through the datapath
   always_comb begin
      state_in = state_ff;
      cmd.op   = gblp_pkg::OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = gblp_pkg::OP_CLR_STEP;
            if (sts.clr_last) state_in = sts.is_clear ? S_FIN : S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = gblp_pkg::OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_clear) state_in = S_CLEAR;
            else if (sts.is_stroke) state_in = S_LINE;
            else state_in = S_FIN;
         end
         S_LINE: begin
            cmd.op   = gblp_pkg::OP_LINE_INIT;
            state_in = S_STAMP;
         end
         S_STAMP: begin
            cmd.op   = gblp_pkg::OP_STAMP_INIT;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.op   = gblp_pkg::OP_RD_ISSUE;
            state_in = S_RDW;
         end
         S_RDW: begin
            cmd.op   = gblp_pkg::OP_RD_WAIT;
            state_in = sts.need_nb ? S_NB : S_WR;
         end
         S_NB: begin
            cmd.op   = gblp_pkg::OP_NB_ISSUE;
            state_in = S_NBW;
         end
         S_NBW: begin
            cmd.op = gblp_pkg::OP_NB_CHECK;
            if (sts.nb_hit || sts.nb_last) state_in = S_WR;
            else state_in = S_NB;
         end
         S_WR: begin
            cmd.op = gblp_pkg::OP_WR_CELL;
            if (!sts.brush_last) state_in = S_RD;
            else if (sts.line_last || !sts.is_move) state_in = S_FIN;
            else state_in = S_STEP;
         end
         S_STEP: begin
            cmd.op   = gblp_pkg::OP_LINE_STEP;
            state_in = S_STAMP;
         end
         S_FIN: begin
            cmd.op   = gblp_pkg::OP_FINISH;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   // a finish is always followed by idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == gblp_pkg::OP_FINISH |=> !busy)
      else $error("finish not followed by idle");
   // an item is latched only from idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == gblp_pkg::OP_LATCH |-> state_ff == S_IDLE && start)
      else $error("item latched outside idle");
   // reads are followed by their wait cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == gblp_pkg::OP_RD_ISSUE |=> cmd.op == gblp_pkg::OP_RD_WAIT)
      else $error("read wait skipped");
endmodule

// File: rtl/core/gblp_datapath.sv
`timescale 1ns / 1ps
module gblp_datapath (
   input  logic              clock,
   input  logic              reset,
   input  gblp_pkg::cmd_type cmd,
   output gblp_pkg::sts_type sts,
   input  logic [2:0]        req_type,
   input  logic [5:0]        req_cell_x,
   input  logic [5:0]        req_cell_y,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [6:0]        csr_wdata,
   output logic              rsp_valid,
   output logic              rsp_grid_changed,
   output logic              rsp_stroke_changed_event,
   output logic              rsp_stroke_rejected_event,
   output logic              rsp_body_bit,
   output logic              rsp_entrance_bit
);
   localparam int AW = gblp_pkg::ADDR_W;
   localparam int CW = gblp_pkg::CRD_W;

   // memories
   logic body_mem [gblp_pkg::CELLS];
   logic entr_mem [gblp_pkg::CELLS];

   // configuration
   logic [6:0] width_ff, height_ff;
   logic [3:0] brush_ff;
   logic [1:0] layer_ff;
   logic       edit_ff;

   // item and stroke state
   logic [2:0] type_ff;
   logic [5:0] x_ff, y_ff;
   logic [5:0] last_x_ff, last_y_ff;
   logic [1:0] drag_ff;
   logic       touched_ff, refused_ff, changed_ff;

   // line walk
   logic signed [CW-1:0] lx_ff, ly_ff, err_ff, dx_ff, dy_ff;
   logic                 sx_ff, sy_ff, paint_ff;
   // brush walk
   logic signed [CW-1:0] ox_ff, oy_ff, rad_ff;
   // neighbor walk
   logic signed [CW-1:0] nx_ff, ny_ff;
   logic                 nb_ok_ff, found_ff;
   // memory read data
   logic                 body_rd_ff, entr_rd_ff;
   // clear sweep; read data of the previous swept cell is pending
   logic [AW-1:0]        clr_ff;
   logic                 clr_chk_ff;

   logic [6:0] eff_w, eff_h;
   assign eff_w = (width_ff  < 7'(gblp_pkg::GRID_COLS)) ? width_ff  : 7'(gblp_pkg::GRID_COLS);
   assign eff_h = (height_ff < 7'(gblp_pkg::GRID_ROWS)) ? height_ff : 7'(gblp_pkg::GRID_ROWS);

   // current brush cell
   logic signed [CW-1:0] cx, cy, nbx, nby;
   logic                 cin;
   logic [AW-1:0]        caddr, naddr, iaddr;
   assign cx  = lx_ff + ox_ff;
   assign cy  = ly_ff + oy_ff;
   assign cin = (cx >= 0) && (cy >= 0) && (cx < CW'(eff_w)) && (cy < CW'(eff_h));
   assign caddr = {cy[gblp_pkg::ROW_W-1:0], cx[gblp_pkg::COL_W-1:0]};
   assign nbx = cx + nx_ff;
   assign nby = cy + ny_ff;
   assign naddr = {nby[gblp_pkg::ROW_W-1:0], nbx[gblp_pkg::COL_W-1:0]};
   assign iaddr = {y_ff, x_ff};

   logic item_in;
   assign item_in = (7'(x_ff) < eff_w) && (7'(y_ff) < eff_h);

   logic is_press, is_move_ok;
   assign is_press   = (type_ff == gblp_pkg::REQ_PRESS_PAINT ||
                        type_ff == gblp_pkg::REQ_PRESS_ERASE) && item_in;
   assign is_move_ok = (type_ff == gblp_pkg::REQ_MOVE) && (drag_ff != 2'd0) && item_in &&
                       !(x_ff == last_x_ff && y_ff == last_y_ff);

   logic [3:0] bs;
   assign bs = (brush_ff == 4'd0) ? 4'd1 :
               (brush_ff > 4'(gblp_pkg::MAX_BRUSH)) ? 4'(gblp_pkg::MAX_BRUSH) : brush_ff;

   // status
   assign sts.clr_last   = (clr_ff == AW'(gblp_pkg::CELLS - 1));
   assign sts.cell_in    = cin;
   assign sts.brush_last = (ox_ff == rad_ff) && (oy_ff == rad_ff);
   assign sts.need_nb    = cin && layer_ff == gblp_pkg::LAYER_ENTR && paint_ff;
   assign sts.nb_hit     = nb_ok_ff && body_rd_ff;
   assign sts.nb_last    = (nx_ff == CW'(gblp_pkg::REACH)) && (ny_ff == CW'(gblp_pkg::REACH));
   assign sts.line_last  = (lx_ff == CW'(x_ff)) && (ly_ff == CW'(y_ff));
   assign sts.is_clear   = (type_ff == gblp_pkg::REQ_CLEAR);
   assign sts.is_stroke  = is_press || is_move_ok;
   assign sts.is_move    = (type_ff == gblp_pkg::REQ_MOVE);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
         brush_ff  <= 4'd1;
         layer_ff  <= gblp_pkg::LAYER_NONE;
         edit_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            gblp_pkg::CSR_WIDTH:    width_ff  <= csr_wdata;
            gblp_pkg::CSR_HEIGHT:   height_ff <= csr_wdata;
            gblp_pkg::CSR_BRUSH:    brush_ff  <= csr_wdata[3:0];
            gblp_pkg::CSR_LAYER:    layer_ff  <= csr_wdata[1:0];
            gblp_pkg::CSR_EDITABLE: edit_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stamped cell new values
   logic wr_body, wr_entr, nb_val, ent_ok;
   logic body_new, entr_new;
   assign ent_ok = found_ff;
   always_comb begin
      wr_body  = 1'b0;
      wr_entr  = 1'b0;
      body_new = 1'b0;
      entr_new = 1'b0;
      if (cin) begin
         case (layer_ff)
            gblp_pkg::LAYER_ERASE: begin
               wr_body = edit_ff;
               wr_entr = 1'b1;
            end
            gblp_pkg::LAYER_BODY: begin
               wr_body  = edit_ff;
               body_new = paint_ff;
            end
            gblp_pkg::LAYER_ENTR: begin
               wr_entr  = !paint_ff || ent_ok;
               entr_new = paint_ff;
            end
            default: ;
         endcase
      end
   end
   assign nb_val = (nbx >= 0) && (nby >= 0) && (nbx < CW'(gblp_pkg::GRID_COLS)) &&
                   (nby < CW'(gblp_pkg::GRID_ROWS));

   // memory ports: one write, registered reads; neighbor probes move only the body read
   logic          bw_en, ew_en, bw_d, ew_d;
   logic [AW-1:0] bw_a, ew_a, br_a, er_a;
   always_comb begin
      bw_en = 1'b0; ew_en = 1'b0; bw_d = 1'b0; ew_d = 1'b0;
      bw_a  = caddr; ew_a = caddr;
      br_a  = caddr; er_a = caddr;
      case (cmd.op)
         gblp_pkg::OP_CLR_STEP: begin
            bw_en = 1'b1; ew_en = 1'b1;
            bw_a = clr_ff; ew_a = clr_ff;
            br_a = clr_ff; er_a = clr_ff;
         end
         gblp_pkg::OP_WR_CELL: begin
            bw_en = wr_body; bw_d = body_new;
            ew_en = wr_entr; ew_d = entr_new;
         end
         gblp_pkg::OP_FINISH: begin
            bw_en = (type_ff == gblp_pkg::REQ_LOAD_BODY) && item_in;
            ew_en = (type_ff == gblp_pkg::REQ_LOAD_ENTR) && item_in;
            bw_d = 1'b1; ew_d = 1'b1; bw_a = iaddr; ew_a = iaddr;
         end
         gblp_pkg::OP_NB_ISSUE: br_a = naddr;
         gblp_pkg::OP_LATCH: begin
            br_a = {req_cell_y, req_cell_x};
            er_a = {req_cell_y, req_cell_x};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (bw_en) body_mem[bw_a] <= bw_d;
      if (ew_en) entr_mem[ew_a] <= ew_d;
      body_rd_ff <= body_mem[br_a];
      entr_rd_ff <= entr_mem[er_a];
   end

   // change detection for a stamped cell or for the swept cell whose read data is registered
   logic cell_chg;
   always_comb begin
      case (cmd.op)
         gblp_pkg::OP_WR_CELL:
            cell_chg = (wr_body && body_rd_ff != body_new) ||
                       (wr_entr && entr_rd_ff != entr_new);
         default:
            cell_chg = clr_chk_ff && sts.is_clear && (body_rd_ff || entr_rd_ff);
      endcase
   end

   // captured read bits of the item cell (read issued at latch)
   logic rb_ff, re_ff;

   // abs and sign of line deltas
   logic signed [CW-1:0] tx, ty, adx, ady, e2;
   assign tx  = CW'(x_ff) - CW'(last_x_ff);
   assign ty  = CW'(y_ff) - CW'(last_y_ff);
   assign adx = tx[CW-1] ? -tx : tx;
   assign ady = ty[CW-1] ? -ty : ty;
   assign e2  = err_ff <<< 1;

   // datapath sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         clr_chk_ff <= 1'b0;
         drag_ff    <= 2'd0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         touched_ff <= 1'b0;
         refused_ff <= 1'b0;
         rsp_valid  <= 1'b0;
         type_ff    <= gblp_pkg::REQ_READ;
         changed_ff <= 1'b0;
      end else begin
         rsp_valid  <= 1'b0;
         clr_chk_ff <= (cmd.op == gblp_pkg::OP_CLR_STEP);
         if (cmd.op == gblp_pkg::OP_LATCH) changed_ff <= 1'b0;
         else if (cell_chg) changed_ff <= 1'b1;
         case (cmd.op)
            gblp_pkg::OP_CLR_STEP: begin
               clr_ff <= sts.clr_last ? '0 : clr_ff + 1'b1;
            end
            gblp_pkg::OP_LATCH: begin
               type_ff    <= req_type;
               x_ff       <= req_cell_x;
               y_ff       <= req_cell_y;
            end
            gblp_pkg::OP_LINE_INIT: begin
               rb_ff <= body_rd_ff;
               re_ff <= entr_rd_ff;
               if (is_press) begin
                  lx_ff    <= CW'(x_ff);
                  ly_ff    <= CW'(y_ff);
                  paint_ff <= (type_ff == gblp_pkg::REQ_PRESS_PAINT);
                  drag_ff  <= (type_ff == gblp_pkg::REQ_PRESS_PAINT) ? 2'd1 : 2'd2;
                  touched_ff <= 1'b0;
                  refused_ff <= 1'b0;
               end else begin
                  lx_ff    <= CW'(last_x_ff);
                  ly_ff    <= CW'(last_y_ff);
                  paint_ff <= (drag_ff == 2'd1);
               end
               dx_ff  <= adx;
               dy_ff  <= ady;
               sx_ff  <= !tx[CW-1] && tx != 0;
               sy_ff  <= !ty[CW-1] && ty != 0;
               err_ff <= adx - ady;
               rad_ff <= CW'((bs - 4'd1) >> 1);
            end
            gblp_pkg::OP_STAMP_INIT: begin
               ox_ff <= -rad_ff;
               oy_ff <= -rad_ff;
            end
            gblp_pkg::OP_RD_WAIT: begin
               nx_ff    <= -CW'(gblp_pkg::REACH);
               ny_ff    <= -CW'(gblp_pkg::REACH);
               found_ff <= 1'b0;
            end
            gblp_pkg::OP_NB_ISSUE: nb_ok_ff <= nb_val;
            gblp_pkg::OP_NB_CHECK: begin
               if (sts.nb_hit) found_ff <= 1'b1;
               if (nx_ff == CW'(gblp_pkg::REACH)) begin
                  nx_ff <= -CW'(gblp_pkg::REACH);
                  ny_ff <= ny_ff + 1'b1;
               end else nx_ff <= nx_ff + 1'b1;
            end
            gblp_pkg::OP_WR_CELL: begin
               if (sts.need_nb && !found_ff) refused_ff <= 1'b1;
               if (ox_ff == rad_ff) begin
                  ox_ff <= -rad_ff;
                  oy_ff <= oy_ff + 1'b1;
               end else ox_ff <= ox_ff + 1'b1;
            end
            gblp_pkg::OP_LINE_STEP: begin
               if (e2 > -dy_ff && e2 < dx_ff) begin
                  err_ff <= err_ff - dy_ff + dx_ff;
                  lx_ff  <= sx_ff ? lx_ff + 1'b1 : lx_ff - 1'b1;
                  ly_ff  <= sy_ff ? ly_ff + 1'b1 : ly_ff - 1'b1;
               end else if (e2 > -dy_ff) begin
                  err_ff <= err_ff - dy_ff;
                  lx_ff  <= sx_ff ? lx_ff + 1'b1 : lx_ff - 1'b1;
               end else if (e2 < dx_ff) begin
                  err_ff <= err_ff + dx_ff;
                  ly_ff  <= sy_ff ? ly_ff + 1'b1 : ly_ff - 1'b1;
               end
            end
            gblp_pkg::OP_FINISH: begin
               rsp_valid <= 1'b1;
               rsp_grid_changed          <= changed_ff || cell_chg ||
                  (((type_ff == gblp_pkg::REQ_LOAD_BODY && !rb_ff) ||
                    (type_ff == gblp_pkg::REQ_LOAD_ENTR && !re_ff)) && item_in);
               rsp_stroke_changed_event  <= 1'b0;
               rsp_stroke_rejected_event <= 1'b0;
               rsp_body_bit              <= 1'b0;
               rsp_entrance_bit          <= 1'b0;
               if (sts.is_stroke) begin
                  last_x_ff <= x_ff;
                  last_y_ff <= y_ff;
                  if (changed_ff) touched_ff <= 1'b1;
               end
               if (type_ff == gblp_pkg::REQ_RELEASE) begin
                  drag_ff    <= 2'd0;
                  touched_ff <= 1'b0;
                  refused_ff <= 1'b0;
                  rsp_stroke_changed_event  <= touched_ff;
                  rsp_stroke_rejected_event <= refused_ff;
               end
               if (type_ff == gblp_pkg::REQ_READ && item_in) begin
                  rsp_body_bit     <= rb_ff;
                  rsp_entrance_bit <= re_ff;
               end
            end
            default: ;
         endcase
         // non-stroke items take their read bits straight after latch
         if (cmd.op == gblp_pkg::OP_NONE && !sts.is_stroke && !sts.is_clear) begin
            rb_ff <= body_rd_ff;
            re_ff <= entr_rd_ff;
         end
      end
   end

   // neighbor scan only on entrance paint
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == gblp_pkg::OP_NB_ISSUE |-> layer_ff == gblp_pkg::LAYER_ENTR && paint_ff)
      else $error("neighbor scan on wrong layer");
   // one result per finish
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.op) == gblp_pkg::OP_FINISH)
      else $error("result without finish");
   // release always leaves no drag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(type_ff) == gblp_pkg::REQ_RELEASE |-> drag_ff == 2'd0)
      else $error("drag kept after release");
endmodule

// File: rtl/core/grid_brush_line_painter.sv
`timescale 1ns / 1ps
// channel    ports                                  handshake
// request    req_type, req_cell_x, req_cell_y       start && !busy
// response   rsp_grid_changed .. rsp_entrance_bit   rsp_valid, one cycle
// config     csr_wr_en, csr_index, csr_wdata        csr_wr_en
// Reset runs a clearing pass over both 4096-cell maps, busy throughout.
// Clear all runs the same clearing pass. Press/move stamp the brush at
// each line point one brush cell at a time, with up to 25 neighbor probes
// per cell on entrance paint. The receiver cannot stall.
module grid_brush_line_painter (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_type,
   input  logic [5:0] req_cell_x,
   input  logic [5:0] req_cell_y,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [6:0] csr_wdata,
   output logic       rsp_valid,
   output logic       rsp_grid_changed,
   output logic       rsp_stroke_changed_event,
   output logic       rsp_stroke_rejected_event,
   output logic       rsp_body_bit,
   output logic       rsp_entrance_bit
);
   gblp_pkg::cmd_type cmd;
   gblp_pkg::sts_type sts;

   gblp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
   );

   gblp_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_type(req_type), .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_grid_changed(rsp_grid_changed),
      .rsp_stroke_changed_event(rsp_stroke_changed_event),
      .rsp_stroke_rejected_event(rsp_stroke_rejected_event),
      .rsp_body_bit(rsp_body_bit), .rsp_entrance_bit(rsp_entrance_bit)
   );
endmodule

// File: tb/sv/grid_brush_line_painter_tb.sv
`timescale 1ns / 1ps
module grid_brush_line_painter_tb;

   localparam int RUN_LIMIT = 6_000_000;

   typedef struct packed {
      logic grid_changed;
      logic stroke_changed;
      logic stroke_rejected;
      logic body_bit;
      logic entrance_bit;
   } paint_result_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_type;
   logic [5:0] req_cell_x;
   logic [5:0] req_cell_y;
   logic       csr_wr_en;
   logic [2:0] csr_index;
   logic [6:0] csr_wdata;
   logic       rsp_valid;
   logic       rsp_grid_changed;
   logic       rsp_stroke_changed_event;
   logic       rsp_stroke_rejected_event;
   logic       rsp_body_bit;
   logic       rsp_entrance_bit;

   grid_brush_line_painter DUT (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_type                  (req_type),
      .req_cell_x                (req_cell_x),
      .req_cell_y                (req_cell_y),
      .csr_wr_en                 (csr_wr_en),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata),
      .rsp_valid                 (rsp_valid),
      .rsp_grid_changed          (rsp_grid_changed),
      .rsp_stroke_changed_event  (rsp_stroke_changed_event),
      .rsp_stroke_rejected_event (rsp_stroke_rejected_event),
      .rsp_body_bit              (rsp_body_bit),
      .rsp_entrance_bit          (rsp_entrance_bit)
   );

   // painter mirror: maps, stroke state and register copies
   bit         body_mirror [0:gblp_pkg::CELLS-1];
   bit         entr_cells [0:gblp_pkg::CELLS-1];
   int         anchor_col, anchor_row;
   int         drag_mode;
   bit         touched, refused, item_hit;
   logic [6:0] cfg_width, cfg_height;
   logic [3:0] cfg_brush;
   logic [1:0] cfg_layer;
   logic       cfg_editable;

   paint_result_type pending_results[$];
   int               error_count;
   int               cycle_count;
   int               send_idle_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("grid_brush_line_painter verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic want, input logic got);
      $display("mismatch %s: expected %0b got %0b at cycle %0d", what, want, got,
               cycle_count);
      error_count++;
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      paint_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 1'b0, 1'b1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_grid_changed !== want.grid_changed)
               report_mismatch("grid_changed", want.grid_changed, rsp_grid_changed);
            if (rsp_stroke_changed_event !== want.stroke_changed)
               report_mismatch("stroke_changed", want.stroke_changed,
                               rsp_stroke_changed_event);
            if (rsp_stroke_rejected_event !== want.stroke_rejected)
               report_mismatch("stroke_rejected", want.stroke_rejected,
                               rsp_stroke_rejected_event);
            if (rsp_body_bit !== want.body_bit)
               report_mismatch("body_bit", want.body_bit, rsp_body_bit);
            if (rsp_entrance_bit !== want.entrance_bit)
               report_mismatch("entrance_bit", want.entrance_bit, rsp_entrance_bit);
         end
      end
   end

   function automatic bit cell_inside(input int x, input int y);
      int w, h;
      w = (cfg_width > gblp_pkg::GRID_COLS) ? gblp_pkg::GRID_COLS : int'(cfg_width);
      h = (cfg_height > gblp_pkg::GRID_ROWS) ? gblp_pkg::GRID_ROWS : int'(cfg_height);
      return x >= 0 && y >= 0 && x < w && y < h;
   endfunction

   function automatic void put_body(input int idx, input bit v);
      if (body_mirror[idx] != v) begin
         body_mirror[idx] = v;
         item_hit = 1;
      end
   endfunction

   function automatic void put_entr(input int idx, input bit v);
      if (entr_cells[idx] != v) begin
         entr_cells[idx] = v;
         item_hit = 1;
      end
   endfunction

   // any body cell within reach, stored array bounds only
   function automatic bit body_in_reach(input int x, input int y);
      int nx, ny;
      for (int oy = -gblp_pkg::REACH; oy <= gblp_pkg::REACH; oy++)
         for (int ox = -gblp_pkg::REACH; ox <= gblp_pkg::REACH; ox++) begin
            nx = x + ox;
            ny = y + oy;
            if (nx >= 0 && ny >= 0 && nx < gblp_pkg::GRID_COLS && ny < gblp_pkg::GRID_ROWS &&
                body_mirror[ny * gblp_pkg::GRID_COLS + nx])
               return 1;
         end
      return 0;
   endfunction

   function automatic void apply_cell(input int x, input int y, input bit paint);
      int idx;
      if (!cell_inside(x, y))
         return;
      idx = y * gblp_pkg::GRID_COLS + x;
      case (cfg_layer)
         gblp_pkg::LAYER_ERASE: begin
            if (cfg_editable)
               put_body(idx, 0);
            put_entr(idx, 0);
         end
         gblp_pkg::LAYER_BODY: begin
            if (cfg_editable)
               put_body(idx, paint);
         end
         gblp_pkg::LAYER_ENTR: begin
            if (!paint)
               put_entr(idx, 0);
            else if (!body_in_reach(x, y))
               refused = 1;
            else
               put_entr(idx, 1);
         end
         default: ;
      endcase
   endfunction

   function automatic void apply_brush(input int x, input int y, input bit paint);
      int side, r;
      side = (cfg_brush < 1) ? 1 :
             ((cfg_brush > gblp_pkg::MAX_BRUSH) ? gblp_pkg::MAX_BRUSH : int'(cfg_brush));
      r = (side - 1) / 2;
      for (int oy = -r; oy <= r; oy++)
         for (int ox = -r; ox <= r; ox++)
            apply_cell(x + ox, y + oy, paint);
   endfunction

   function automatic void walk_line(input int x0, input int y0, input int x1,
                                     input int y1, input bit paint);
      int dx, dy, sx, sy, err, e2;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      forever begin
         apply_brush(x0, y0, paint);
         if (x0 == x1 && y0 == y1)
            break;
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            x0 += sx;
         end
         if (e2 < dx) begin
            err += dx;
            y0 += sy;
         end
      end
   endfunction

   // advance the mirror by one item and return its result
   function automatic paint_result_type paint_step(input logic [2:0] kind, input int x,
                                                   input int y);
      paint_result_type res;
      res = '0;
      item_hit = 0;
      case (kind)
         gblp_pkg::REQ_PRESS_PAINT, gblp_pkg::REQ_PRESS_ERASE: begin
            if (cell_inside(x, y)) begin
               drag_mode = (kind == gblp_pkg::REQ_PRESS_PAINT) ? 1 : 2;
               anchor_col = x;
               anchor_row = y;
               touched = 0;
               refused = 0;
               apply_brush(x, y, drag_mode == 1);
               if (item_hit)
                  touched = 1;
            end
         end
         gblp_pkg::REQ_MOVE: begin
            if (drag_mode != 0 && cell_inside(x, y) &&
                !(x == anchor_col && y == anchor_row)) begin
               walk_line(anchor_col, anchor_row, x, y, drag_mode == 1);
               anchor_col = x;
               anchor_row = y;
               if (item_hit)
                  touched = 1;
            end
         end
         gblp_pkg::REQ_RELEASE: begin
            drag_mode = 0;
            res.stroke_changed = touched;
            res.stroke_rejected = refused;
            touched = 0;
            refused = 0;
         end
         gblp_pkg::REQ_LOAD_BODY:
            if (cell_inside(x, y)) put_body(y * gblp_pkg::GRID_COLS + x, 1);
         gblp_pkg::REQ_LOAD_ENTR:
            if (cell_inside(x, y)) put_entr(y * gblp_pkg::GRID_COLS + x, 1);
         gblp_pkg::REQ_CLEAR: begin
            for (int i = 0; i < gblp_pkg::CELLS; i++) begin
               put_body(i, 0);
               put_entr(i, 0);
            end
         end
         default: begin
            if (cell_inside(x, y)) begin
               res.body_bit = body_mirror[y * gblp_pkg::GRID_COLS + x];
               res.entrance_bit = entr_cells[y * gblp_pkg::GRID_COLS + x];
            end
         end
      endcase
      res.grid_changed = item_hit;
      return res;
   endfunction

   // present one item, hold until accepted, then maybe idle
   task automatic send_item(input logic [2:0] kind, input logic [5:0] x, input logic [5:0] y);
      start <= 1'b1;
      req_type <= kind;
      req_cell_x <= x;
      req_cell_y <= y;
      do
         @(posedge clock);
      while (busy);
      pending_results.push_back(paint_step(kind, int'(x), int'(y)));
      if ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold until every result is in, then let the block settle
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // drive one register write; the caller drops the enable afterwards
   task automatic write_reg(input logic [2:0] idx, input logic [6:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         gblp_pkg::CSR_WIDTH:    cfg_width = value;
         gblp_pkg::CSR_HEIGHT:   cfg_height = value;
         gblp_pkg::CSR_BRUSH:    cfg_brush = value[3:0];
         gblp_pkg::CSR_LAYER:    cfg_layer = value[1:0];
         gblp_pkg::CSR_EDITABLE: cfg_editable = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [6:0] w, input logic [6:0] h, input logic [3:0] brush,
                             input logic [1:0] layer, input logic editable);
      wait_drained();
      write_reg(gblp_pkg::CSR_WIDTH, w);
      write_reg(gblp_pkg::CSR_HEIGHT, h);
      write_reg(gblp_pkg::CSR_BRUSH, {3'b000, brush});
      write_reg(gblp_pkg::CSR_LAYER, {5'b00000, layer});
      write_reg(gblp_pkg::CSR_EDITABLE, {6'b000000, editable});
      csr_wr_en <= 1'b0;
   endtask

   // corners, loads, reads and the grid bound
   task automatic test_loads_and_reads();
      set_config(7'd64, 7'd64, 4'd1, gblp_pkg::LAYER_NONE, 1'b1);
      send_item(gblp_pkg::REQ_READ, 6'd0, 6'd0);
      send_item(gblp_pkg::REQ_LOAD_BODY, 6'd63, 6'd63);
      send_item(gblp_pkg::REQ_LOAD_ENTR, 6'd63, 6'd63);
      send_item(gblp_pkg::REQ_LOAD_ENTR, 6'd63, 6'd63);
      send_item(gblp_pkg::REQ_READ, 6'd63, 6'd63);
      set_config(7'd127, 7'd0, 4'd1, gblp_pkg::LAYER_NONE, 1'b1);
      send_item(gblp_pkg::REQ_LOAD_BODY, 6'd2, 6'd2);
      send_item(gblp_pkg::REQ_READ, 6'd63, 6'd63);
      set_config(7'd10, 7'd10, 4'd1, gblp_pkg::LAYER_NONE, 1'b1);
      send_item(gblp_pkg::REQ_LOAD_BODY, 6'd10, 6'd3);
      send_item(gblp_pkg::REQ_READ, 6'd63, 6'd63);
      send_item(gblp_pkg::REQ_MOVE, 6'd3, 6'd3);
      send_item(gblp_pkg::REQ_RELEASE, 6'd0, 6'd0);
   endtask

   // strokes on the body, entrance and erase layers, entrance rejects, eraser and clear all
   task automatic test_strokes();
      set_config(7'd64, 7'd64, 4'd12, gblp_pkg::LAYER_BODY, 1'b1);
      send_item(gblp_pkg::REQ_PRESS_PAINT, 6'd0, 6'd0);
      send_item(gblp_pkg::REQ_MOVE, 6'd0, 6'd0);
      send_item(gblp_pkg::REQ_MOVE, 6'd9, 6'd4);
      send_item(gblp_pkg::REQ_RELEASE, 6'd0, 6'd0);
      set_config(7'd64, 7'd64, 4'd0, gblp_pkg::LAYER_ENTR, 1'b0);
      send_item(gblp_pkg::REQ_PRESS_PAINT, 6'd12, 6'd12);
      send_item(gblp_pkg::REQ_MOVE, 6'd16, 6'd5);
      send_item(gblp_pkg::REQ_RELEASE, 6'd0, 6'd0);
      send_item(gblp_pkg::REQ_PRESS_PAINT, 6'd40, 6'd40);
      send_item(gblp_pkg::REQ_RELEASE, 6'd0, 6'd0);
      send_item(gblp_pkg::REQ_READ, 6'd12, 6'd12);
      set_config(7'd64, 7'd64, 4'd15, gblp_pkg::LAYER_BODY, 1'b0);
      send_item(gblp_pkg::REQ_PRESS_ERASE, 6'd4, 6'd4);
      send_item(gblp_pkg::REQ_RELEASE, 6'd0, 6'd0);
      set_config(7'd64, 7'd64, 4'd3, gblp_pkg::LAYER_ERASE, 1'b1);
      send_item(gblp_pkg::REQ_PRESS_PAINT, 6'd5, 6'd2);
      send_item(gblp_pkg::REQ_MOVE, 6'd1, 6'd6);
      send_item(gblp_pkg::REQ_RELEASE, 6'd0, 6'd0);
      send_item(gblp_pkg::REQ_CLEAR, 6'd0, 6'd0);
      send_item(gblp_pkg::REQ_READ, 6'd63, 6'd63);
   endtask

   function automatic logic [5:0] near_coord(input int c);
      int v;
      v = c + int'($urandom_range(12)) - 6;
      return (v < 0) ? 6'd0 : ((v > 63) ? 6'd63 : 6'(v));
   endfunction

   // random strokes with random content, plus loose items
   task automatic test_random_phase(input int item_goal, input int idle_pct);
      int sent, moves;
      logic [5:0] x, y;
      logic [2:0] kind;
      logic [6:0] w, h;
      send_idle_pct = idle_pct;
      w = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'd64;
      h = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'd64;
      set_config(w, h, 4'($urandom_range(1, 5)), 2'($urandom_range(3)),
                 1'($urandom_range(1)));
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(9) < 6) begin
            x = 6'($urandom);
            y = 6'($urandom);
            send_item($urandom_range(1) ? gblp_pkg::REQ_PRESS_PAINT : gblp_pkg::REQ_PRESS_ERASE,
                      x, y);
            moves = $urandom_range(1, 4);
            for (int i = 0; i < moves; i++) begin
               x = near_coord(x);
               y = near_coord(y);
               send_item(gblp_pkg::REQ_MOVE, x, y);
            end
            if ($urandom_range(4) == 0)
               send_item(gblp_pkg::REQ_LOAD_BODY, near_coord(x), near_coord(y));
            send_item(gblp_pkg::REQ_RELEASE, 6'($urandom), 6'($urandom));
            sent += moves + 2;
         end else begin
            kind = 3'($urandom_range(7));
            if (kind == gblp_pkg::REQ_CLEAR && $urandom_range(5) != 0)
               kind = gblp_pkg::REQ_READ;
            send_item(kind, 6'($urandom), 6'($urandom));
            sent++;
         end
      end
      // pause until the block has answered everything
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = gblp_pkg::REQ_READ;
      req_cell_x = '0;
      req_cell_y = '0;
      csr_wr_en = 1'b0;
      csr_index = gblp_pkg::CSR_WIDTH;
      csr_wdata = '0;
      error_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      for (int i = 0; i < gblp_pkg::CELLS; i++) begin
         body_mirror[i] = 0;
         entr_cells[i] = 0;
      end
      anchor_col = 0;
      anchor_row = 0;
      drag_mode = 0;
      touched = 0;
      refused = 0;
      cfg_width = 7'd64;
      cfg_height = 7'd64;
      cfg_brush = 4'd1;
      cfg_layer = gblp_pkg::LAYER_NONE;
      cfg_editable = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_loads_and_reads();
      test_strokes();
      test_random_phase(36, 0);
      test_random_phase(36, 87);
      test_random_phase(36, 25);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("grid_brush_line_painter verification clean");
      else
         $display("grid_brush_line_painter verification failed");
      $finish;
   end
endmodule
